/* rtl/core/lcd_number_formatter_defines.svh */
// Assertion macros for the LCD number formatter.
// Expects signals named clock and reset in the module that uses them.
`ifndef LCD_NUMBER_FORMATTER_DEFINES_SVH
`define LCD_NUMBER_FORMATTER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LCDNF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define LCDNF_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/core/lcdnf_pkg.sv */
// Shared types, codes and constants for the LCD number formatter.
// No dependencies.
package lcdnf_pkg;

   localparam int unsigned NUM_W      = 16;
   localparam int unsigned BCD_DIGITS = 5;

   localparam logic [2:0] OP_CHAR = 3'd0;
   localparam logic [2:0] OP_UDEC = 3'd1;
   localparam logic [2:0] OP_SDEC = 3'd2;
   localparam logic [2:0] OP_HEX  = 3'd3;
   localparam logic [2:0] OP_BIN  = 3'd4;

   localparam logic [1:0] LINE_FIRST  = 2'd1;
   localparam logic [1:0] LINE_SECOND = 2'd2;

   localparam logic [7:0] CURSOR_BASE  = 8'h80;
   localparam logic [7:0] LINE2_OFFSET = 8'h40;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;

   typedef struct packed {
      logic [2:0]       op;
      logic [1:0]       line;
      logic [4:0]       column;
      logic [NUM_W-1:0] number;
      logic [4:0]       digit_count;
      logic [7:0]       char_code;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   // ASCII for one digit, '0'-'9' then 'A'-'F'.
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] d_ext;
      d_ext = {4'b0000, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + d_ext;
      end else begin
         return CHAR_UPPER_A + d_ext - 8'd10;
      end
   endfunction

endpackage

/* rtl/core/lcd_number_formatter.sv */
// Character LCD number formatter: one request in, a run of bus writes out.
// Depends on lcdnf_pkg and lcd_number_formatter_defines.svh.
//
// Usage:
//   A request transfers at a rising edge with start high and busy low. Ops 5 to
//   7 are dropped at once and busy stays low. Any other op raises busy.
//   The number is first shifted in one bit per cycle, through a
//   double-dabble BCD register for decimal or a nibble shift line for hex and
//   binary. The writes then follow one per cycle: cursor command (lines 1
//   and 2 only), then the character or sign, then the digits, most
//   significant first. Each write shows on rsp_data for one cycle with
//   rsp_valid high; last marks the final write of the request.
//   busy stays high from the request edge through the conversion and every
//   write, so the block takes no new request until the last write of the
//   one before is shown. A request makes at most 18 writes.
//   busy drops in the cycle the last write is shown, so a new request may
//   transfer while it is still on the result ports.
//   The receiver cannot stall: every write is taken in its one cycle.
//   Reset clears the sequencer and the result strobe; no request is pending.
`include "lcd_number_formatter_defines.svh"

module lcd_number_formatter
   import lcdnf_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int unsigned IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int unsigned DIG_N  = (MAX_DIGITS > BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
   localparam int unsigned DIGF_W = 4 * DIG_N;
   localparam int unsigned BIT_W  = $clog2(NUM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_CURSOR,
      ST_LEAD,
      ST_DIGIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [2:0]                 op_ff, op_in;
   logic [NUM_W-1:0]           value_ff, value_in;
   logic [DIG_N-1:0][3:0]      digits_ff, digits_in;
   logic [BIT_W-1:0]           bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [7:0]                 cursor_ff, cursor_in;
   logic [7:0]                 lead_ff, lead_in;
   logic                       has_cursor_ff, has_cursor_in;
   logic                       has_lead_ff, has_lead_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic [BCD_DIGITS-1:0][3:0] dab;
   logic [BCD_DIGITS*4-1:0]    dab_flat;
   logic [DIGF_W-1:0]          digits_flat;
   logic                       bit_in;
   logic [CNT_W-1:0]           cnt_dec;
   logic [IDX_W-1:0]           digit_idx;
   logic [7:0]                 offset;
   state_type                  after_lead, after_cursor, after_convert;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bit_in      = value_ff[NUM_W-1];
   assign digits_flat = digits_ff;
   assign cnt_dec     = count_ff - 1'b1;
   assign digit_idx   = cnt_dec[IDX_W-1:0];
   assign offset      = (req_data.line == LINE_SECOND) ? LINE2_OFFSET : 8'h00;

   // Add 3 to any BCD digit of five or more before the shift.
   always_comb begin
      for (int j = 0; j < BCD_DIGITS; j++) begin
         dab[j] = (digits_ff[j] >= 4'd5) ? (digits_ff[j] + 4'd3) : digits_ff[j];
      end
      dab_flat = dab;
   end

   assign after_lead    = (count_ff != '0) ? ST_DIGIT : ST_IDLE;
   assign after_cursor  = has_lead_ff ? ST_LEAD : after_lead;
   assign after_convert = has_cursor_ff ? ST_CURSOR : after_cursor;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      digits_in     = digits_ff;
      bit_cnt_in    = bit_cnt_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      lead_in       = lead_ff;
      has_cursor_in = has_cursor_ff;
      has_lead_in   = has_lead_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start && (req_data.op inside {[OP_CHAR:OP_BIN]})) begin
               op_in      = req_data.op;
               bit_cnt_in = '0;
               digits_in  = '0;
               if ((req_data.op == OP_SDEC) && req_data.number[NUM_W-1]) begin
                  value_in = '0 - req_data.number;
               end else begin
                  value_in = req_data.number;
               end
               if (req_data.op == OP_CHAR) begin
                  count_in = '0;
               end else if (req_data.digit_count > 5'(MAX_DIGITS)) begin
                  count_in = CNT_W'(MAX_DIGITS);
               end else begin
                  count_in = CNT_W'(req_data.digit_count);
               end
               cursor_in = CURSOR_BASE
                           | ({3'b000, req_data.column} + 8'hFF + offset);
               has_cursor_in = (req_data.line == LINE_FIRST)
                               || (req_data.line == LINE_SECOND);
               has_lead_in = (req_data.op == OP_CHAR) || (req_data.op == OP_SDEC);
               if (req_data.op == OP_CHAR) begin
                  lead_in = req_data.char_code;
               end else if (req_data.number[NUM_W-1]) begin
                  lead_in = CHAR_MINUS;
               end else begin
                  lead_in = CHAR_PLUS;
               end
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            value_in   = {value_ff[NUM_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            case (op_ff)
               OP_UDEC, OP_SDEC: begin
                  digits_in = '0;
                  digits_in[BCD_DIGITS-1:0] = {dab_flat[BCD_DIGITS*4-2:0], bit_in};
               end
               OP_HEX: begin
                  digits_in = {digits_flat[DIGF_W-2:0], bit_in};
               end
               OP_BIN: begin
                  digits_in = {digits_ff[DIG_N-2:0], {3'b000, bit_in}};
               end
               default: begin
                  digits_in = digits_ff;
               end
            endcase
            if (bit_cnt_ff == BIT_W'(NUM_W - 1)) begin
               state_in = after_convert;
            end
         end
         ST_CURSOR: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{reg_select: 1'b0, bus_byte: cursor_ff,
                             last: (after_cursor == ST_IDLE)};
            state_in     = after_cursor;
         end
         ST_LEAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{reg_select: 1'b1, bus_byte: lead_ff,
                             last: (after_lead == ST_IDLE)};
            state_in     = after_lead;
         end
         ST_DIGIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{reg_select: 1'b1, bus_byte: digit_char(digits_ff[digit_idx]),
                             last: (cnt_dec == '0)};
            count_in     = cnt_dec;
            // Advance until the least significant digit has gone out.
            state_in     = (cnt_dec == '0) ? ST_IDLE : ST_DIGIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      digits_ff     <= digits_in;
      bit_cnt_ff    <= bit_cnt_in;
      count_ff      <= count_in;
      cursor_ff     <= cursor_in;
      lead_ff       <= lead_in;
      has_cursor_ff <= has_cursor_in;
      has_lead_ff   <= has_lead_in;
      rsp_data_ff   <= rsp_data_in;
   end

   `LCDNF_ASSERT_NEXT(a_run_unbroken, rsp_valid && !rsp_data.last, rsp_valid,
                      "writes of one request must follow back to back")
   `LCDNF_ASSERT(a_free_after_last, !(rsp_valid && rsp_data.last) || !busy,
                 "busy must be low while the final write is shown")
   `LCDNF_ASSERT_NEXT(a_one_command, rsp_valid && !rsp_data.reg_select,
                      !(rsp_valid && !rsp_data.reg_select),
                      "at most one cursor command per request")
   `LCDNF_ASSERT_NEXT(a_busy_on_transfer,
                      start && !busy && (req_data.op == OP_CHAR || req_data.op == OP_UDEC
                      || req_data.op == OP_SDEC || req_data.op == OP_HEX
                      || req_data.op == OP_BIN),
                      busy, "a valid request must raise busy")

endmodule

/* test/lcd_number_formatter_tb.sv */
// Self-checking testbench for lcd_number_formatter: drives display requests and
// compares every LCD bus write against writes predicted from the request.
// Depends on lcdnf_pkg and the lcd_number_formatter RTL.
module lcd_number_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcdnf_pkg::*;

   localparam int unsigned DIGIT_LIMIT  = 16;
   localparam logic [2:0]  OP_SPARE_LOW = 3'd5;
   localparam logic [2:0]  OP_SPARE_MID = 3'd6;
   localparam logic [2:0]  OP_CODE_TOP  = 3'd7;
   localparam logic [1:0]  LINE_NONE    = 2'd0;
   localparam logic [1:0]  LINE_SPARE   = 2'd3;
   localparam int          RANDOM_ITEMS = 350;
   localparam int          PHASES       = 5;
   localparam int          SETTLE_LIMIT = 4000;
   localparam int          TAIL_CYCLES  = 40;
   localparam int          MAX_REPORTS  = 10;

   // Predicts the write run of each request and checks the writes as they come.
   class write_scoreboard;
      rsp_type expected_writes[$];
      int      mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void add_write(logic rs, logic [7:0] bus);
         rsp_type w;
         w.reg_select = rs;
         w.bus_byte   = bus;
         w.last       = 1'b0;
         expected_writes.push_back(w);
      endfunction

      function void note_request(req_type r);
         int unsigned count;
         int unsigned radix;
         int unsigned magnitude;
         int unsigned v;
         int unsigned d;
         int          first;
         int          pos;
         logic [7:0]  col_byte;
         rsp_type     tail;
         first     = expected_writes.size();
         radix     = 10;
         magnitude = 32'(r.number);
         col_byte  = {3'b000, r.column};
         // Unused op codes are dropped without any write.
         if (r.op > OP_BIN) begin
            return;
         end
         count = (r.digit_count > DIGIT_LIMIT) ? DIGIT_LIMIT : 32'(r.digit_count);
         // Cursor address wraps modulo 256 before the command bit is set.
         if (r.line == LINE_FIRST) begin
            add_write(1'b0, CURSOR_BASE | (col_byte - 8'd1));
         end else if (r.line == LINE_SECOND) begin
            add_write(1'b0, CURSOR_BASE | (col_byte - 8'd1 + LINE2_OFFSET));
         end
         if (r.op == OP_CHAR) begin
            add_write(1'b1, r.char_code);
         end else begin
            if (r.op == OP_SDEC) begin
               if (r.number[15]) begin
                  add_write(1'b1, CHAR_MINUS);
                  magnitude = 32'h10000 - r.number;
               end else begin
                  add_write(1'b1, CHAR_PLUS);
               end
            end else if (r.op == OP_HEX) begin
               radix = 16;
            end else if (r.op == OP_BIN) begin
               radix = 2;
            end
            for (pos = int'(count) - 1; pos >= 0; pos--) begin
               v = magnitude;
               for (int i = 0; i < pos && v != 0; i++) begin
                  v = v / radix;
               end
               d = v % radix;
               if (d < 10) begin
                  add_write(1'b1, CHAR_ZERO + 8'(d));
               end else begin
                  add_write(1'b1, CHAR_UPPER_A + 8'(d - 10));
               end
            end
         end
         if (expected_writes.size() > first) begin
            tail      = expected_writes.pop_back();
            tail.last = 1'b1;
            expected_writes.push_back(tail);
         end
      endfunction

      function void check_write(rsp_type got);
         rsp_type want;
         if (expected_writes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected write: rs=%0b byte=%02h last=%0b",
                        got.reg_select, got.bus_byte, got.last);
            end
            return;
         end
         want = expected_writes.pop_front();
         if (got.reg_select !== want.reg_select || got.bus_byte !== want.bus_byte ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display({"write mismatch: expected rs=%0b byte=%02h last=%0b,",
                         " got rs=%0b byte=%02h last=%0b"},
                        want.reg_select, want.bus_byte, want.last,
                        got.reg_select, got.bus_byte, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   write_scoreboard board;

   lcd_number_formatter #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("lcd_number_formatter verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_write(rsp_data);
      end
   end

   function automatic req_type make_request(logic [2:0] op, logic [1:0] line,
                                            logic [4:0] column, logic [15:0] number,
                                            logic [4:0] count, logic [7:0] ch);
      req_type r;
      r.op          = op;
      r.line        = line;
      r.column      = column;
      r.number      = number;
      r.digit_count = count;
      r.char_code   = ch;
      return r;
   endfunction

   // Hold start low for the gap, then present the request until it transfers.
   task automatic send_request(req_type r, int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.note_request(r);
   endtask

   initial begin
      req_type directed[$];
      req_type r;
      int      idle_pct[PHASES];
      int      gap;
      int      sent;
      int      guard;

      idle_pct = '{0, 72, 8, 0, 72};
      board    = new();
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_request(OP_CHAR, LINE_FIRST, 5'd1, 16'h0000, 5'd0, 8'h00));
      directed.push_back(make_request(OP_CHAR, LINE_SECOND, 5'd16, 16'hFFFF, 5'd31, 8'hFF));
      directed.push_back(make_request(OP_CHAR, LINE_NONE, 5'd31, 16'h1234, 5'd3, 8'h5A));
      directed.push_back(make_request(OP_CHAR, LINE_SPARE, 5'd7, 16'h0000, 5'd0, 8'hA5));
      // Column zero wraps the cursor address.
      directed.push_back(make_request(OP_CHAR, LINE_FIRST, 5'd0, 16'h0000, 5'd0, 8'h41));
      directed.push_back(make_request(OP_CHAR, LINE_SECOND, 5'd0, 16'h0000, 5'd0, 8'h42));
      directed.push_back(make_request(OP_UDEC, LINE_FIRST, 5'd31, 16'hFFFF, 5'd16, 8'h00));
      directed.push_back(make_request(OP_UDEC, LINE_SECOND, 5'd31, 16'h0000, 5'd0, 8'hFF));
      directed.push_back(make_request(OP_UDEC, LINE_NONE, 5'd1, 16'h0000, 5'd0, 8'h00));
      directed.push_back(make_request(OP_UDEC, LINE_FIRST, 5'd3, 16'd12345, 5'd5, 8'h00));
      directed.push_back(make_request(OP_UDEC, LINE_SPARE, 5'd9, 16'd65535, 5'd31, 8'h00));
      directed.push_back(make_request(OP_UDEC, LINE_SECOND, 5'd4, 16'd907, 5'd17, 8'h00));
      directed.push_back(make_request(OP_SDEC, LINE_FIRST, 5'd2, 16'h8000, 5'd5, 8'h00));
      directed.push_back(make_request(OP_SDEC, LINE_SECOND, 5'd2, 16'h0000, 5'd3, 8'h00));
      directed.push_back(make_request(OP_SDEC, LINE_NONE, 5'd8, 16'h7FFF, 5'd5, 8'h00));
      directed.push_back(make_request(OP_SDEC, LINE_SPARE, 5'd8, 16'hFFFF, 5'd0, 8'h00));
      directed.push_back(make_request(OP_SDEC, LINE_FIRST, 5'd16, 16'h8000, 5'd31, 8'h00));
      directed.push_back(make_request(OP_HEX, LINE_FIRST, 5'd1, 16'hFFFF, 5'd16, 8'h00));
      directed.push_back(make_request(OP_HEX, LINE_SECOND, 5'd12, 16'hA5C3, 5'd4, 8'h00));
      directed.push_back(make_request(OP_HEX, LINE_NONE, 5'd1, 16'h0BEF, 5'd0, 8'h00));
      directed.push_back(make_request(OP_BIN, LINE_FIRST, 5'd1, 16'hFFFF, 5'd16, 8'h00));
      directed.push_back(make_request(OP_BIN, LINE_SPARE, 5'd5, 16'h5555, 5'd20, 8'h00));
      directed.push_back(make_request(OP_SPARE_LOW, LINE_FIRST, 5'd1, 16'hFFFF, 5'd16,
                                      8'hFF));
      directed.push_back(make_request(OP_SPARE_MID, LINE_SECOND, 5'd2, 16'h1234, 5'd4,
                                      8'h11));
      directed.push_back(make_request(OP_CODE_TOP, LINE_FIRST, 5'd3, 16'h0000, 5'd0, 8'h00));

      foreach (directed[i]) begin
         send_request(directed[i], 0);
      end

      sent = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         while (sent < (phase + 1) * RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(99) < 8) begin
               r.op = 3'($urandom_range(OP_CODE_TOP, OP_BIN + 1));
            end else begin
               r.op = 3'($urandom_range(OP_BIN, OP_CHAR));
            end
            r.line = 2'($urandom_range(3));
            if ($urandom_range(99) < 85) begin
               r.column = 5'($urandom_range(16, 1));
            end else begin
               r.column = 5'($urandom_range(31));
            end
            if ($urandom_range(99) < 30) begin
               r.number = 16'($urandom_range(99));
            end else begin
               r.number = 16'($urandom);
            end
            // Mostly legal digit counts, with some that saturate.
            if ($urandom_range(99) < 85) begin
               r.digit_count = 5'($urandom_range(DIGIT_LIMIT));
            end else begin
               r.digit_count = 5'($urandom_range(31));
            end
            r.char_code = 8'($urandom);
            gap = 0;
            while (gap < 40 && $urandom_range(99) < idle_pct[phase]) begin
               gap++;
            end
            send_request(r, gap);
            sent++;
         end
      end

      @(negedge clock);
      start <= 1'b0;
      guard = 0;
      while (board.pending() != 0 && guard < SETTLE_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("lcd_number_formatter verification clean");
      end else begin
         $display("lcd_number_formatter verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lcdnf_pkg.sv
rtl/core/lcd_number_formatter.sv
test/lcd_number_formatter_tb.sv
